// ----- sv/psf_pkg.sv -----
// Shared types, constants and helpers of the push-sum flow-updating node.
// No dependencies; used by every module of the block.
package psf_pkg;

    // Field widths of the item and result channels
    localparam int ADDR_W     = 48;
    localparam int WORD_W     = 32;
    localparam int PIDX_W     = 5;
    localparam int PCNT_W     = 6;
    localparam int LEN_W      = 8;
    localparam int OPC_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Defaults and fixed values
    localparam int PEERS_DEFAULT = 32;
    localparam int FRACTION_BITS = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam logic [LEN_W-1:0]  ACCEPT_LENGTH = 8'd8;
    localparam logic [WORD_W-1:0] WEIGHT_ONE    = 32'(64'd1 << FRACTION_BITS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_INIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_INIT = 2'd2;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_SEND  = 2'd2,
        OP_RECV  = 2'd3
    } t_opcode;

    // Command classes after the front end has screened the item
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_START,
        CMD_SEND,
        CMD_RECV
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [PIDX_W-1:0]   peer_index;
        logic [ADDR_W-1:0]   peer_address;
        logic [WORD_W-1:0]   flow_value;
        logic [WORD_W-1:0]   flow_weight;
    } t_cmd;

    typedef struct packed {
        logic                send_valid;
        logic [ADDR_W-1:0]   send_address;
        logic [WORD_W-1:0]   sent_flow_value;
        logic [WORD_W-1:0]   sent_flow_weight;
        logic                receive_accepted;
        logic [WORD_W-1:0]   current_value;
        logic [WORD_W-1:0]   current_weight;
    } t_result;

    // Start values handed to the execution engine
    typedef struct packed {
        logic [WORD_W-1:0]   value_init;
        logic [WORD_W-1:0]   weight_init;
    } t_node_cfg;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    // Arithmetic shift right by one, rounds toward minus infinity
    function automatic logic [WORD_W-1:0] halve(input logic [WORD_W-1:0] v);
        return {v[WORD_W-1], v[WORD_W-1:1]};
    endfunction

endpackage

// ----- sv/psf_fifo.sv -----
// Small register queue used between front end, engine and result port.
// Depends on psf_pkg for the queue depth.
module psf_fifo #(
    parameter int W = psf_pkg::CMD_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int DEPTH = psf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/psf_front.sv -----
// Front end: takes input transactions and screens them into engine commands.
// Depends on psf_pkg for the command type and opcodes.
module psf_front #(
    parameter  int PEERS = psf_pkg::PEERS_DEFAULT,
    localparam int CNT_W = $clog2(PEERS + 1),
    localparam int NW    = (CNT_W > psf_pkg::PCNT_W) ? CNT_W : psf_pkg::PCNT_W
) (
    input  logic                              i_push,
    input  logic [psf_pkg::OPC_W-1:0]         i_opcode,
    input  logic [psf_pkg::PIDX_W-1:0]        i_peer_index,
    input  logic [psf_pkg::ADDR_W-1:0]        i_peer_address,
    input  logic [psf_pkg::WORD_W-1:0]        i_flow_value,
    input  logic [psf_pkg::WORD_W-1:0]        i_flow_weight,
    input  logic [psf_pkg::LEN_W-1:0]         i_payload_length,
    input  logic [NW-1:0]                     i_n_used,
    input  logic                              i_q_full,
    output logic                              o_full,
    output logic                              o_q_push,
    output psf_pkg::t_cmd                     o_cmd
);

    localparam logic [NW-1:0] PEERS_N = NW'(PEERS);

    logic [NW-1:0] idx_ext;

    assign idx_ext  = NW'(i_peer_index);
    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    // classify: out-of-range and malformed items become no-ops
    always_comb begin
        o_cmd.peer_index   = i_peer_index;
        o_cmd.peer_address = i_peer_address;
        o_cmd.flow_value   = i_flow_value;
        o_cmd.flow_weight  = i_flow_weight;
        case (psf_pkg::t_opcode'(i_opcode))
            psf_pkg::OP_LOAD: begin
                o_cmd.kind = (idx_ext < PEERS_N) ? psf_pkg::CMD_LOAD : psf_pkg::CMD_NOP;
            end
            psf_pkg::OP_START: begin
                o_cmd.kind = psf_pkg::CMD_START;
            end
            psf_pkg::OP_SEND: begin
                o_cmd.kind = (idx_ext < i_n_used) ? psf_pkg::CMD_SEND : psf_pkg::CMD_NOP;
            end
            psf_pkg::OP_RECV: begin
                o_cmd.kind = (i_payload_length == psf_pkg::ACCEPT_LENGTH) ?
                             psf_pkg::CMD_RECV : psf_pkg::CMD_NOP;
            end
            default: begin
                o_cmd.kind = psf_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

// ----- sv/psf_back.sv -----
// Execution engine: node state, peer table memories and the receive scan.
// Depends on psf_pkg for command, result and configuration types.
module psf_back #(
    parameter  int PEERS = psf_pkg::PEERS_DEFAULT,
    localparam int CNT_W = $clog2(PEERS + 1),
    localparam int NW    = (CNT_W > psf_pkg::PCNT_W) ? CNT_W : psf_pkg::PCNT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_empty,
    input  psf_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    input  logic [NW-1:0]         i_n_used,
    input  psf_pkg::t_node_cfg    i_node_cfg,
    input  logic                  i_res_full,
    output logic                  o_res_push,
    output psf_pkg::t_result      o_res
);

    localparam int IDX_W  = $clog2(PEERS);
    localparam int WW     = psf_pkg::WORD_W;
    localparam int AW     = psf_pkg::ADDR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEND,
        S_SCAN,
        S_RECV
    } t_state;

    t_state             r_state, n_state;
    psf_pkg::t_cmd      r_cmd, n_cmd;
    logic [NW-1:0]      r_idx, n_idx;
    logic               r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic [WW-1:0]      r_value, n_value;
    logic [WW-1:0]      r_weight, n_weight;

    // peer table: address, sent flows {value, weight}, received flows
    logic [AW-1:0]      r_addr_mem [PEERS];
    logic [2*WW-1:0]    r_sent_mem [PEERS];
    logic [2*WW-1:0]    r_recv_mem [PEERS];
    logic [AW-1:0]      r_addr_rd;
    logic [2*WW-1:0]    r_sent_rd;
    logic [2*WW-1:0]    r_recv_rd;

    logic [IDX_W-1:0]   addr_ra, sent_ra, recv_ra;
    logic               addr_we, sent_we, recv_we;
    logic [IDX_W-1:0]   tbl_wa, recv_wa;
    logic [2*WW-1:0]    sent_wd, recv_wd;

    logic [IDX_W-1:0]   in_tidx, cur_tidx;
    logic               hit;
    logic [WW-1:0]      half_v, half_w, sum_v, sum_w;

    assign in_tidx  = IDX_W'(i_cmd.peer_index);
    assign cur_tidx = IDX_W'(r_cmd.peer_index);
    assign hit      = r_chk_valid && (r_addr_rd == r_cmd.peer_address);
    assign half_v   = psf_pkg::halve(r_value);
    assign half_w   = psf_pkg::halve(r_weight);
    assign sum_v    = r_sent_rd[2*WW-1:WW] + half_v;
    assign sum_w    = r_sent_rd[WW-1:0] + half_w;

    // command sequencing and datapath
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_chk_valid = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_value     = r_value;
        n_weight    = r_weight;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        addr_ra     = r_idx[IDX_W-1:0];
        sent_ra     = cur_tidx;
        recv_ra     = r_chk_idx;
        addr_we     = 1'b0;
        sent_we     = 1'b0;
        recv_we     = 1'b0;
        tbl_wa      = cur_tidx;
        recv_wa     = r_chk_idx;
        sent_wd     = '0;
        recv_wd     = '0;
        case (r_state)
            S_IDLE: begin
                // a result slot is free whenever a command is taken
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    case (i_cmd.kind)
                        psf_pkg::CMD_LOAD: begin
                            addr_we    = 1'b1;
                            sent_we    = 1'b1;
                            recv_we    = 1'b1;
                            tbl_wa     = in_tidx;
                            recv_wa    = in_tidx;
                            o_res_push = 1'b1;
                        end
                        psf_pkg::CMD_START: begin
                            n_value    = i_node_cfg.value_init;
                            n_weight   = i_node_cfg.weight_init;
                            o_res_push = 1'b1;
                        end
                        psf_pkg::CMD_SEND: begin
                            addr_ra = in_tidx;
                            sent_ra = in_tidx;
                            n_state = S_SEND;
                        end
                        psf_pkg::CMD_RECV: begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_SEND: begin
                n_value                = half_v;
                n_weight               = half_w;
                sent_we                = 1'b1;
                sent_wd                = {sum_v, sum_w};
                o_res_push             = 1'b1;
                o_res.send_valid       = 1'b1;
                o_res.send_address     = r_addr_rd;
                o_res.sent_flow_value  = sum_v;
                o_res.sent_flow_weight = sum_w;
                n_state                = S_IDLE;
            end
            S_SCAN: begin
                // one address read issued and one compared per cycle
                if (hit) begin
                    recv_ra = r_chk_idx;
                    n_state = S_RECV;
                end else if (r_idx >= i_n_used) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    addr_ra     = r_idx[IDX_W-1:0];
                    n_chk_valid = 1'b1;
                    n_chk_idx   = r_idx[IDX_W-1:0];
                    n_idx       = r_idx + 1'b1;
                end
            end
            S_RECV: begin
                n_value = r_value + (r_cmd.flow_value - r_recv_rd[2*WW-1:WW]);
                n_weight = r_weight + (r_cmd.flow_weight - r_recv_rd[WW-1:0]);
                recv_we                = 1'b1;
                recv_wd                = {r_cmd.flow_value, r_cmd.flow_weight};
                o_res_push             = 1'b1;
                o_res.receive_accepted = 1'b1;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_res.current_value  = n_value;
        o_res.current_weight = n_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_valid <= 1'b0;
            r_value     <= '0;
            r_weight    <= '0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= n_chk_valid;
            r_value     <= n_value;
            r_weight    <= n_weight;
        end
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
    end

    // peer table memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (addr_we) begin
            r_addr_mem[tbl_wa] <= i_cmd.peer_address;
        end
        r_addr_rd <= r_addr_mem[addr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sent_we) begin
            r_sent_mem[tbl_wa] <= sent_wd;
        end
        r_sent_rd <= r_sent_mem[sent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (recv_we) begin
            r_recv_mem[recv_wa] <= recv_wd;
        end
        r_recv_rd <= r_recv_mem[recv_ra];
    end

endmodule

// ----- sv/push_sum_flow_updating.sv -----
// Push-sum averaging node with flow updating; top level with config registers.
// A result reaches the outputs via the command queue, engine and result queue. The engine
// handles load, start and no-ops in idle, a transmit in idle and send states, a receive in
// idle, a scan of up to the effective peer count of addresses through the table's single
// read port and, on a match, its receive state. Reset is synchronous, active low: node value
// and weight clear, queues empty, peer addresses undefined until loaded.
module push_sum_flow_updating #(
    parameter int PEERS = psf_pkg::PEERS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic        [psf_pkg::OPC_W-1:0]     i_opcode,
    input  logic        [psf_pkg::PIDX_W-1:0]    i_peer_index,
    input  logic        [psf_pkg::ADDR_W-1:0]    i_peer_address,
    input  logic signed [psf_pkg::WORD_W-1:0]    i_flow_value,
    input  logic signed [psf_pkg::WORD_W-1:0]    i_flow_weight,
    input  logic        [psf_pkg::LEN_W-1:0]     i_payload_length,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 o_send_valid,
    output logic        [psf_pkg::ADDR_W-1:0]    o_send_address,
    output logic signed [psf_pkg::WORD_W-1:0]    o_sent_flow_value,
    output logic signed [psf_pkg::WORD_W-1:0]    o_sent_flow_weight,
    output logic                                 o_receive_accepted,
    output logic signed [psf_pkg::WORD_W-1:0]    o_current_value,
    output logic signed [psf_pkg::WORD_W-1:0]    o_current_weight,
    input  logic                                 i_cfg_we,
    input  logic        [psf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [psf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(PEERS + 1);
    localparam int NW    = (CNT_W > psf_pkg::PCNT_W) ? CNT_W : psf_pkg::PCNT_W;
    localparam logic [NW-1:0] PEERS_N = NW'(PEERS);

    logic [psf_pkg::PCNT_W-1:0] r_peer_count;
    logic [psf_pkg::WORD_W-1:0] r_value_init;
    logic [psf_pkg::WORD_W-1:0] r_weight_init;

    logic [NW-1:0]              peer_ext, n_used;
    psf_pkg::t_node_cfg         node_cfg;
    psf_pkg::t_cmd              front_cmd, cmd_head;
    logic [psf_pkg::CMD_W-1:0]  cmd_head_bits;
    logic                       cmd_push, cmd_full, cmd_empty, cmd_pop;
    psf_pkg::t_result           res_in, res_out;
    logic [psf_pkg::RES_W-1:0]  res_head_bits;
    logic                       res_push, res_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_count  <= '0;
            r_value_init  <= '0;
            r_weight_init <= psf_pkg::WEIGHT_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psf_pkg::CFG_PEER_COUNT:  r_peer_count  <= i_cfg_data[psf_pkg::PCNT_W-1:0];
                psf_pkg::CFG_VALUE_INIT:  r_value_init  <= i_cfg_data;
                psf_pkg::CFG_WEIGHT_INIT: r_weight_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entries in use, clipped to the table size
    assign peer_ext = NW'(r_peer_count);
    assign n_used   = (peer_ext > PEERS_N) ? PEERS_N : peer_ext;
    assign node_cfg.value_init  = r_value_init;
    assign node_cfg.weight_init = r_weight_init;

    psf_front #(
        .PEERS (PEERS)
    ) u_front (
        .i_push           (push),
        .i_opcode         (i_opcode),
        .i_peer_index     (i_peer_index),
        .i_peer_address   (i_peer_address),
        .i_flow_value     (i_flow_value),
        .i_flow_weight    (i_flow_weight),
        .i_payload_length (i_payload_length),
        .i_n_used         (n_used),
        .i_q_full         (cmd_full),
        .o_full           (full),
        .o_q_push         (cmd_push),
        .o_cmd            (front_cmd)
    );

    psf_fifo #(
        .W (psf_pkg::CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head_bits),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    assign cmd_head = psf_pkg::t_cmd'(cmd_head_bits);

    psf_back #(
        .PEERS (PEERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_n_used    (n_used),
        .i_node_cfg  (node_cfg),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    psf_fifo #(
        .W (psf_pkg::RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_head_bits),
        .o_full  (res_full),
        .o_empty (empty)
    );

    // result port from the queue head
    assign res_out            = psf_pkg::t_result'(res_head_bits);
    assign o_send_valid       = res_out.send_valid;
    assign o_send_address     = res_out.send_address;
    assign o_sent_flow_value  = res_out.sent_flow_value;
    assign o_sent_flow_weight = res_out.sent_flow_weight;
    assign o_receive_accepted = res_out.receive_accepted;
    assign o_current_value    = res_out.current_value;
    assign o_current_weight   = res_out.current_weight;

    // engine never pushes into a full result queue
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // a command is only taken when its result has room
    a_pop_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> (!cmd_empty && !res_full))
        else $error("command taken without result room");

    // a result never both sends and accepts a receive
    a_exclusive_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_send_valid && o_receive_accepted))
        else $error("send and receive flagged together");

    // send fields are zero when nothing was sent
    a_send_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_send_valid) |->
        (o_send_address == '0 && o_sent_flow_value == '0 && o_sent_flow_weight == '0))
        else $error("send fields set without a send");

endmodule
